FILE: hw/rtl/ddsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddsp_pkg;

  localparam int MAX_DAY_DIGIT_COUNT = 19;
  localparam int MAX_FRACTION_DIGITS = 9;

  localparam logic [31:0] DAY_LENGTH_RESET = 32'd86400;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_DAY    = 2'd1;
  localparam logic [1:0] PH_FRAC   = 2'd2;
  localparam logic [1:0] PH_REJECT = 2'd3;

  localparam logic [1:0] DIV_FRAC = 2'd0;
  localparam logic [1:0] DIV_REF  = 2'd1;
  localparam logic [1:0] DIV_DAY  = 2'd2;

  localparam logic [1:0] MUL_FRAC = 2'd0;
  localparam logic [1:0] MUL_LO   = 2'd1;
  localparam logic [1:0] MUL_HI   = 2'd2;

  typedef struct packed {
    logic       parse_en;
    logic       clear;
    logic       div_start;
    logic [1:0] div_sel;
    logic       lat_frac;
    logic       lat_ref;
    logic       set_day;
    logic       adj_day;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum_en;
    logic       load_out;
  } ddsp_cmd_t;

  typedef struct packed {
    logic rej;
    logic need_cpl;
    logic div_done;
  } ddsp_sts_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] v;
    case (n)
      5'd0:  v = 64'd1;
      5'd1:  v = 64'd10;
      5'd2:  v = 64'd100;
      5'd3:  v = 64'd1000;
      5'd4:  v = 64'd10000;
      5'd5:  v = 64'd100000;
      5'd6:  v = 64'd1000000;
      5'd7:  v = 64'd10000000;
      5'd8:  v = 64'd100000000;
      5'd9:  v = 64'd1000000000;
      5'd10: v = 64'd10000000000;
      5'd11: v = 64'd100000000000;
      5'd12: v = 64'd1000000000000;
      5'd13: v = 64'd10000000000000;
      5'd14: v = 64'd100000000000000;
      5'd15: v = 64'd1000000000000000;
      5'd16: v = 64'd10000000000000000;
      5'd17: v = 64'd100000000000000000;
      5'd18: v = 64'd1000000000000000000;
      5'd19: v = 64'd10000000000000000000;
      default: v = 64'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/decimal_day_stamp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Non-final characters: one per cycle, no result.
// Final character: the result is computed after it is taken (two 64-step serial
// divisions for fraction rounding and reference day, a third one when partial day
// digits are completed, none when rejected); input stalls until the result is loaded.
// A finished result waits in the output register while the next stamp streams in.
// Synchronous active-low reset: day length 86400, parser at start of stamp.
module decimal_day_stamp_parser
  import ddsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_ch,
  input  wire logic               in_last,
  input  wire logic signed [63:0] in_reference_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_status,
  output logic signed [63:0]      out_stamp_seconds,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  ddsp_cmd_t   cmd;
  ddsp_sts_t   sts;
  logic [63:0] stamp;

  ddsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ddsp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .ch            (in_ch),
    .ref_time      (in_reference_time),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .status        (out_status),
    .stamp_seconds (stamp)
  );

  assign out_stamp_seconds = stamp;

endmodule
`default_nettype wire

FILE: hw/rtl/ddsp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ddsp_div
  import ddsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [DIV_CNT_W-1:0] CntOne  = DIV_CNT_W'(1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [63:0]          rem_r, rem_nxt;
  logic [63:0]          dvs_r, dvs_nxt;
  logic [64:0]          shifted;
  logic [64:0]          diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[63:0] : shifted[63:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + CntOne;
      if (cnt_r == CntLast) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ddsp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ddsp_dp
  import ddsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ddsp_cmd_t   cmd,
  output ddsp_sts_t        sts,
  input  wire logic [7:0]  ch,
  input  wire logic [63:0] ref_time,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output logic             status,
  output logic [63:0]      stamp_seconds
);

  logic [31:0] len_r, len_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        plus_r, plus_nxt;
  logic [4:0]  ddc_r, ddc_nxt;
  logic [62:0] dval_r, dval_nxt;
  logic [29:0] fnum_r, fnum_nxt;
  logic [3:0]  fdc_r, fdc_nxt;

  logic [63:0] ref_r;
  logic [31:0] frac_r;
  logic        refneg_r;
  logic [63:0] refmag_r;
  logic [63:0] daymag_r;
  logic        dayneg_r;
  logic [63:0] plo_r;
  logic [63:0] phi_r;
  logic [95:0] p_r;
  logic        status_r;
  logic [63:0] stamp_r;

  logic        digit;
  logic [3:0]  dv;
  logic [66:0] dtry;
  logic [33:0] ftry;
  logic [63:0] pw_day;
  logic [63:0] pw_frac;
  logic [63:0] div_a, div_b;
  logic        div_done;
  logic [63:0] div_q, div_r;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [64:0] pos_sum;
  logic [63:0] neg_lim;
  logic        range_ok;
  logic [63:0] res;

  assign digit  = (ch >= 8'h30) && (ch <= 8'h39);
  assign dv     = digit ? 4'(ch - 8'h30) : 4'd0;
  assign dtry   = {1'b0, dval_r, 3'b0} + {3'b0, dval_r, 1'b0} + 67'(dv);
  assign ftry   = {1'b0, fnum_r, 3'b0} + {3'b0, fnum_r, 1'b0} + 34'(dv);
  assign pw_day  = pow10(ddc_r);
  assign pw_frac = pow10({1'b0, fdc_r});

  always_comb begin
    phase_nxt = phase_r;
    plus_nxt  = plus_r;
    ddc_nxt   = ddc_r;
    dval_nxt  = dval_r;
    fnum_nxt  = fnum_r;
    fdc_nxt   = fdc_r;
    if (cmd.clear) begin
      phase_nxt = PH_START;
      plus_nxt  = 1'b0;
      ddc_nxt   = '0;
      dval_nxt  = '0;
      fnum_nxt  = '0;
      fdc_nxt   = '0;
    end else if (cmd.parse_en && phase_r != PH_REJECT) begin
      if (phase_r == PH_START && ch == 8'h2B) begin
        plus_nxt  = 1'b1;
        phase_nxt = PH_DAY;
      end else if (phase_r != PH_FRAC && ch == 8'h2E) begin
        phase_nxt = PH_FRAC;
      end else if (!digit) begin
        phase_nxt = PH_REJECT;
      end else if (phase_r == PH_FRAC) begin
        if (fdc_r < 4'(MAX_FRACTION_DIGITS)) begin
          fnum_nxt = ftry[29:0];
          fdc_nxt  = fdc_r + 4'd1;
        end
      end else if (ddc_r >= 5'(MAX_DAY_DIGIT_COUNT) || dtry[66:63] != 4'd0) begin
        phase_nxt = PH_REJECT;
      end else begin
        ddc_nxt   = ddc_r + 5'd1;
        dval_nxt  = dtry[62:0];
        phase_nxt = PH_DAY;
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (cfg_we && cfg_wdata != 32'd0) begin
      len_nxt = cfg_wdata;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_FRAC: begin
        div_a = plo_r + {1'b0, pw_frac[63:1]};
        div_b = pw_frac;
      end
      DIV_REF: begin
        div_a = ref_r[63] ? ((64'd0 - ref_r) + {32'd0, len_r} - 64'd1) : ref_r;
        div_b = {32'd0, len_r};
      end
      DIV_DAY: begin
        div_a = refmag_r - {1'b0, dval_r};
        div_b = pw_day;
      end
      default: begin
        div_a = ref_r;
        div_b = {32'd0, len_r};
      end
    endcase
  end

  ddsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    case (cmd.mul_sel)
      MUL_FRAC: mul_a = {2'b0, fnum_r};
      MUL_LO:   mul_a = daymag_r[31:0];
      MUL_HI:   mul_a = daymag_r[63:32];
      default:  mul_a = '0;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(len_r);

  assign pos_sum  = {1'b0, p_r[63:0]} + {33'd0, frac_r};
  assign neg_lim  = {1'b1, 63'd0} + {32'd0, frac_r};
  always_comb begin
    if (dayneg_r) begin
      range_ok = (p_r[95:64] == 32'd0) && (p_r[63:0] <= neg_lim);
      res      = {32'd0, frac_r} - p_r[63:0];
    end else begin
      range_ok = (p_r[95:63] == 33'd0) && (pos_sum[64:63] == 2'd0);
      res      = pos_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= DAY_LENGTH_RESET;
      phase_r <= PH_START;
      plus_r  <= 1'b0;
      ddc_r   <= '0;
      dval_r  <= '0;
      fnum_r  <= '0;
      fdc_r   <= '0;
    end else begin
      len_r   <= len_nxt;
      phase_r <= phase_nxt;
      plus_r  <= plus_nxt;
      ddc_r   <= ddc_nxt;
      dval_r  <= dval_nxt;
      fnum_r  <= fnum_nxt;
      fdc_r   <= fdc_nxt;
    end
    if (cmd.parse_en) begin
      ref_r <= ref_time;
    end
    if (cmd.lat_frac) begin
      frac_r <= div_q[31:0];
    end
    if (cmd.lat_ref) begin
      refmag_r <= div_q;
      refneg_r <= ref_r[63];
    end
    if (cmd.set_day) begin
      if (ddc_r == 5'd0) begin
        daymag_r <= refmag_r;
        dayneg_r <= refneg_r;
      end else begin
        daymag_r <= {1'b0, dval_r};
        dayneg_r <= 1'b0;
      end
    end else if (cmd.adj_day) begin
      daymag_r <= refmag_r - div_r + ((plus_r && div_r != 64'd0) ? pw_day : 64'd0);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_sel == MUL_HI) begin
        phi_r <= mul_p;
      end else begin
        plo_r <= mul_p;
      end
    end
    if (cmd.sum_en) begin
      p_r <= {phi_r, 32'd0} + {32'd0, plo_r};
    end
    if (cmd.load_out) begin
      status_r <= sts.rej || !range_ok;
      stamp_r  <= (sts.rej || !range_ok) ? 64'd0 : res;
    end
  end

  assign sts.rej      = (phase_r == PH_REJECT) || (ddc_r == 5'd0 && fdc_r == 4'd0);
  assign sts.need_cpl = !refneg_r && (ddc_r != 5'd0) && (refmag_r >= pw_day);
  assign sts.div_done = div_done;

  assign status        = status_r;
  assign stamp_seconds = stamp_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ddsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ddsp_ctrl
  import ddsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      in_last,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ddsp_cmd_t      cmd,
  input  wire ddsp_sts_t sts
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_MULF    = 4'd2;
  localparam logic [3:0] S_DIVF_GO = 4'd3;
  localparam logic [3:0] S_DIVF_W  = 4'd4;
  localparam logic [3:0] S_DIVR_GO = 4'd5;
  localparam logic [3:0] S_DIVR_W  = 4'd6;
  localparam logic [3:0] S_DECIDE  = 4'd7;
  localparam logic [3:0] S_DIVD_GO = 4'd8;
  localparam logic [3:0] S_DIVD_W  = 4'd9;
  localparam logic [3:0] S_MULLO   = 4'd10;
  localparam logic [3:0] S_MULHI   = 4'd11;
  localparam logic [3:0] S_SUM     = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       in_acc;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !ovalid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    ovalid_nxt  = ovalid_r && out_stall;
    cmd         = '0;
    cmd.div_sel = DIV_FRAC;
    cmd.mul_sel = MUL_FRAC;
    case (state_r)
      S_IDLE: begin
        cmd.parse_en = in_acc;
        if (in_acc && in_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.rej ? S_FIN : S_MULF;
      end
      S_MULF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FRAC;
        state_nxt   = S_DIVF_GO;
      end
      S_DIVF_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FRAC;
        state_nxt     = S_DIVF_W;
      end
      S_DIVF_W: begin
        if (sts.div_done) begin
          cmd.lat_frac = 1'b1;
          state_nxt    = S_DIVR_GO;
        end
      end
      S_DIVR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_REF;
        state_nxt     = S_DIVR_W;
      end
      S_DIVR_W: begin
        if (sts.div_done) begin
          cmd.lat_ref = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_day = 1'b1;
        state_nxt   = sts.need_cpl ? S_DIVD_GO : S_MULLO;
      end
      S_DIVD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DAY;
        state_nxt     = S_DIVD_W;
      end
      S_DIVD_W: begin
        cmd.div_sel = DIV_DAY;
        if (sts.div_done) begin
          cmd.adj_day = 1'b1;
          state_nxt   = S_MULLO;
        end
      end
      S_MULLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_nxt   = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule
`default_nettype wire

FILE: tb/sv/decimal_day_stamp_parser_test.sv
`timescale 1ns / 1ps
module decimal_day_stamp_parser_test;
  import ddsp_pkg::*;

  localparam longint unsigned I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned I64_MIN = 64'h8000_0000_0000_0000;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic        status;
    logic [63:0] seconds;
  } stamp_result_t;

  class stamp_scoreboard;
    logic [31:0]   day_len;
    logic [1:0]    phase;
    bit            plus_seen;
    int unsigned   day_digits;
    logic [63:0]   day_value;
    logic [63:0]   frac_num;
    int unsigned   frac_digits;
    stamp_result_t pending[$];
    int unsigned   errors;

    function void clear_stamp();
      phase = PH_START;
      plus_seen = 0;
      day_digits = 0;
      day_value = 0;
      frac_num = 0;
      frac_digits = 0;
    endfunction

    function void reset_state();
      day_len = DAY_LENGTH_RESET;
      errors = 0;
      clear_stamp();
    endfunction

    function void set_day_length(logic [31:0] v);
      if (v != 0) day_len = v;
    endfunction

    function void take_char(logic [7:0] c);
      bit numeric;
      logic [63:0] dv;
      numeric = c >= "0" && c <= "9";
      dv = numeric ? 64'(c - "0") : 64'd0;
      if (phase == PH_REJECT) return;
      if (phase == PH_START && c == "+") begin
        plus_seen = 1;
        phase = PH_DAY;
        return;
      end
      if (phase != PH_FRAC && c == ".") begin
        phase = PH_FRAC;
        return;
      end
      if (!numeric) begin
        phase = PH_REJECT;
        return;
      end
      if (phase == PH_FRAC) begin
        if (frac_digits < MAX_FRACTION_DIGITS) begin
          frac_num = frac_num * 10 + dv;
          frac_digits++;
        end
        return;
      end
      if (day_digits + 1 > MAX_DAY_DIGIT_COUNT || day_value > (I64_MAX - dv) / 10) begin
        phase = PH_REJECT;
        return;
      end
      day_digits++;
      day_value = day_value * 10 + dv;
      phase = PH_DAY;
    endfunction

    function int unsigned decimal_width(logic [63:0] v);
      int unsigned n;
      n = 1;
      while (v >= 10) begin
        v = v / 10;
        n++;
      end
      return n;
    endfunction

    function bit compose_stamp(logic [63:0] now, output logic [63:0] res);
      logic [63:0] len, den, frac, ref_mag, day_mag, m, d, q, p, lim;
      bit ref_neg, day_neg;
      res = 0;
      len = {32'd0, day_len};
      if (phase == PH_REJECT || day_digits + frac_digits == 0) return 0;
      den = 1;
      for (int i = 0; i < frac_digits; i++) den = den * 10;
      frac = (frac_num * len + den / 2) / den;
      if (now[63]) begin
        ref_neg = 1;
        ref_mag = (64'd0 - now + len - 1) / len;
      end else begin
        ref_neg = 0;
        ref_mag = now / len;
      end
      if (day_digits == 0) begin
        day_neg = ref_neg;
        day_mag = ref_mag;
      end else if (ref_neg || day_digits >= decimal_width(ref_mag)) begin
        day_neg = 0;
        day_mag = day_value;
      end else begin
        m = 1;
        for (int i = 0; i < day_digits; i++) m = m * 10;
        d = ref_mag - day_value;
        q = plus_seen ? (d + m - 1) / m : d / m;
        day_neg = 0;
        day_mag = day_value + q * m;
      end
      if (!day_neg) begin
        if (day_mag > I64_MAX / len) return 0;
        p = day_mag * len;
        if (frac > I64_MAX - p) return 0;
        res = p + frac;
      end else begin
        lim = I64_MIN + frac;
        if (day_mag > lim / len) return 0;
        res = frac - day_mag * len;
      end
      return 1;
    endfunction

    function void note_char(logic [7:0] c, bit last, logic [63:0] now);
      stamp_result_t r;
      logic [63:0] v;
      take_char(c);
      if (!last) return;
      r.status = !compose_stamp(now, v);
      r.seconds = r.status ? 64'd0 : v;
      pending.push_back(r);
      clear_stamp();
    endfunction

    function void check_result(logic status, logic [63:0] seconds);
      stamp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d seconds=%0d", $time, status,
                 $signed(seconds));
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (seconds !== e.seconds) begin
        $display("%0t: stamp_seconds expected %0d actual %0d", $time,
                 $signed(e.seconds), $signed(seconds));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        in_last;
  logic [63:0] in_reference_time;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [63:0] out_stamp_seconds;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  stamp_scoreboard board;
  bit          calm;
  bit          hold_off;
  int unsigned cycles;

  decimal_day_stamp_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch), .in_last(in_last),
    .in_reference_time(in_reference_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_stamp_seconds(out_stamp_seconds),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_status, out_stamp_seconds);
  end

  // stall the result side in random bursts; hold off long when asked
  initial begin
    int n;
    out_stall = 1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        out_stall <= 1;
        n = $urandom_range(16, 1);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 0;
        n = $urandom_range(16, 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] random_time();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(2_000_000_000));
      2: return -64'($urandom_range(2_000_000_000));
      3: return $urandom_range(1) ? I64_MAX - $urandom_range(1000) : I64_MIN + $urandom_range(1000);
      default: return 64'd1_700_000_000 + $urandom_range(100_000_000);
    endcase
  endfunction

  task automatic send_char(logic [7:0] c, bit last, logic [63:0] now);
    int n;
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 0;
      n = $urandom_range(16, 1);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_ch <= c;
    in_last <= last;
    in_reference_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_char(c, last, now);
  endtask

  task automatic send_stamp(string s, logic [63:0] now);
    if (s.len() == 0) begin
      send_char(8'(";"), 1, now);
      return;
    end
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, now);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_day_length(logic [31:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_day_length(v);
  endtask

  function automatic string random_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string random_stamp();
    string s;
    s = $urandom_range(1) ? "+" : "";
    if ($urandom_range(3) != 0) s = {s, random_digits($urandom_range(20))};
    if ($urandom_range(1)) s = {s, ".", random_digits($urandom_range(12))};
    if ($urandom_range(9) == 0) s = {s, string'(8'($urandom_range(255)))};
    if ($urandom_range(15) == 0) s = {s, "."};
    if (s.len() == 0) s = "7";
    return s;
  endfunction

  task automatic random_phase(int count);
    string s;
    for (int k = 0; k < count;) begin
      if ($urandom_range(7) == 0) begin
        send_char(8'($urandom_range(255)), $urandom_range(1), random_time());
        k++;
      end else begin
        s = random_stamp();
        send_stamp(s, random_time());
        k += s.len();
      end
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    rst_n = 0;
    in_valid = 0;
    in_ch = 0;
    in_last = 0;
    in_reference_time = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    calm = 0;
    hold_off = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_stamp("+123.5", 64'd1_700_000_000);
    send_stamp("45", 64'd1_700_000_000);
    send_stamp(".5", 64'd1_700_000_000);
    send_stamp(".999999999999", -64'd1);
    send_stamp("9223372036854775807", 64'd0);
    send_stamp("9223372036854775808", 64'd0);
    send_stamp("12345678901234567890", 64'd0);
    send_stamp("1.2.3", 64'd0);
    send_stamp("+", 64'd0);
    send_stamp(".", 64'd0);
    send_stamp("", 64'd0);
    send_char(8'd0, 1, 64'd0);
    send_char(8'hFF, 1, I64_MIN);
    send_stamp("3+", I64_MAX);
    send_stamp(".0", I64_MIN);
    send_stamp("+9", I64_MAX);
    send_stamp("99999", 64'd5);
    drain();

    write_day_length(32'd0);
    write_day_length(32'hFFFF_FFFF);
    random_phase(200);
    drain();
    write_day_length(32'd1);
    send_stamp("9223372036854775807.6", 64'd0);
    random_phase(200);
    drain();
    write_day_length(32'd3600);
    hold_off = 1;
    random_phase(250);
    drain();
    write_day_length(32'($urandom_range(100000, 2)));
    random_phase(300);
    drain();
    write_day_length(DAY_LENGTH_RESET);
    calm = 1;
    random_phase(250);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
